// ===== hdl/mbcbm_pkg.sv =====
// Shared types and constants for the MBC1 bank mapper.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mbcbm_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_LOAD_ROM = 2'd2,
    OP_LOAD_RAM = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic CFG_ROM_COUNT = 1'b0;
  localparam logic CFG_RAM_COUNT = 1'b1;

  localparam int unsigned BANK_W      = 7;   // upper_bank:rom_bank_low
  localparam int unsigned DIV_CNT_W   = 3;
  localparam int unsigned ROM_OFS_W   = 14;  // 16 KiB bank
  localparam int unsigned RAM_OFS_W   = 13;  // 8 KiB bank
  localparam int unsigned LOAD_OFS_W  = 21;
  localparam logic [7:0]  READ_OPEN   = 8'hFF;
  localparam logic [3:0]  RAM_EN_KEY  = 4'hA;

  // Controller to datapath
  typedef struct packed {
    logic take_item;
    logic div_start;
    logic div_step;
    logic mem_go;
    logic result_load;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/mbcbm_ram.sv =====
// Generic single-port RAM with registered read data.
// Stand-alone; used for the ROM and external RAM stores.
`default_nettype none

module mbcbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mbcbm_ctrl.sv =====
// Sequencing state machine for the MBC1 bank mapper.
// Depends on mbcbm_pkg; drives the datapath through ctl_cmd_t.
`default_nettype none

module mbcbm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire mbcbm_pkg::dp_stat_t  stat_i,
  output mbcbm_pkg::ctl_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MEM  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d         = S_PREP;
        end
      end
      S_PREP: begin
        if (stat_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_MEM;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_MEM;
        end
      end
      S_MEM: begin
        cmd_o.mem_go = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (slot_free) begin
          cmd_o.result_load = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result_load |-> slot_free)
    else $error("result loaded over an untaken item");
  a_accept_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_PREP))
    else $error("accepted item not started");
  a_div_runs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !stat_i.div_last) |=> (state_q == S_DIV))
    else $error("bank reduction cut short");
  a_mem_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MEM) |=> (state_q == S_DONE))
    else $error("memory access not followed by result stage");
  a_result_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result_load |=> out_valid_o)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ===== hdl/mbcbm_dp.sv =====
// Datapath of the MBC1 bank mapper: item and control registers, bank
// reduction divider, ROM and RAM stores. Depends on mbcbm_pkg and mbcbm_ram.
`default_nettype none

module mbcbm_dp #(
  parameter int unsigned ROM_BANKS_MAX = 128,
  parameter int unsigned RAM_BANKS_MAX = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [7:0]          cfg_data_i,
  input  wire logic [1:0]          op_i,
  input  wire logic [15:0]         bus_address_i,
  input  wire logic [7:0]          write_data_i,
  input  wire logic [20:0]         load_offset_i,
  input  wire mbcbm_pkg::ctl_cmd_t cmd_i,
  output mbcbm_pkg::dp_stat_t      stat_o,
  output logic [7:0]               read_data_o
);

  localparam int unsigned BW        = mbcbm_pkg::BANK_W;
  localparam int unsigned ROM_BYTES = ROM_BANKS_MAX * (2 ** mbcbm_pkg::ROM_OFS_W);
  localparam int unsigned RAM_BYTES = RAM_BANKS_MAX * (2 ** mbcbm_pkg::RAM_OFS_W);
  localparam int unsigned ROM_AW    = $clog2(ROM_BYTES);
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);
  localparam int unsigned OW        = mbcbm_pkg::LOAD_OFS_W;

  // item registers
  logic [1:0]  op_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;
  logic [20:0] off_q;

  // configuration and bank control
  logic [7:0] rom_cnt_q;
  logic [2:0] ram_cnt_q;
  logic       ram_en_q, mode_q;
  logic [4:0] bank_lo_q;
  logic [1:0] upper_q;

  // divider
  logic [BW-1:0]                  dvd_q, rem_q, rem_d;
  logic [mbcbm_pkg::DIV_CNT_W-1:0] dcnt_q;
  logic [BW:0]                    trial, divisor;
  logic [BW-1:0]                  dividend;

  logic [7:0] rom_eff;
  logic [2:0] ram_eff;
  logic       rom_rgn, ram_rgn, ram_live;
  logic       is_read, is_write;
  logic       rom_we, rom_re, ram_we, ram_re;
  logic [20:0] rom_lin;
  logic [19:0] ram_lin;
  logic [ROM_AW-1:0] rom_addr;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0] rom_rdata, ram_rdata, result;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      op_q    <= op_i;
      addr_q  <= bus_address_i;
      wdata_q <= write_data_i;
      off_q   <= load_offset_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_cnt_q <= 8'd2;
      ram_cnt_q <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mbcbm_pkg::CFG_ROM_COUNT: rom_cnt_q <= cfg_data_i;
        mbcbm_pkg::CFG_RAM_COUNT: ram_cnt_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rom_cnt_q == 8'd0) begin
      rom_eff = 8'd1;
    end else if (rom_cnt_q > 8'(ROM_BANKS_MAX)) begin
      rom_eff = 8'(ROM_BANKS_MAX);
    end else begin
      rom_eff = rom_cnt_q;
    end
    ram_eff = (ram_cnt_q > 3'(RAM_BANKS_MAX)) ? 3'(RAM_BANKS_MAX) : ram_cnt_q;
  end

  assign is_read  = (op_q == mbcbm_pkg::OP_READ);
  assign is_write = (op_q == mbcbm_pkg::OP_WRITE);
  assign rom_rgn  = !addr_q[15];
  assign ram_rgn  = (addr_q[15:13] == 3'b101);
  assign ram_live = ram_en_q && (ram_eff != 3'd0);

  assign stat_o.need_div = (is_read && rom_rgn) ||
                           ((is_read || is_write) && ram_rgn && ram_live);

  // dividend and divisor of the bank reduction
  always_comb begin
    if (rom_rgn) begin
      divisor = rom_eff;
      if (addr_q[14]) begin
        dividend = {upper_q, bank_lo_q};
      end else begin
        dividend = mode_q ? {upper_q, 5'd0} : '0;
      end
    end else begin
      divisor  = {5'd0, ram_eff};
      dividend = mode_q ? {5'd0, upper_q} : '0;
    end
  end

  // restoring remainder, one dividend bit a step
  assign trial = {rem_q, dvd_q[BW-1]};
  assign rem_d = (trial >= divisor) ? BW'(trial - divisor) : trial[BW-1:0];
  assign stat_o.div_last = (dcnt_q == mbcbm_pkg::DIV_CNT_W'(BW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= dividend;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[BW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // bank control registers, written by bus writes below 0x8000
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_en_q  <= 1'b0;
      mode_q    <= 1'b0;
      bank_lo_q <= 5'd1;
      upper_q   <= 2'd0;
    end else if (cmd_i.mem_go && is_write && rom_rgn) begin
      unique case (addr_q[14:13])
        2'd0: ram_en_q <= (wdata_q[3:0] == mbcbm_pkg::RAM_EN_KEY);
        2'd1: bank_lo_q <= (wdata_q[4:0] == 5'd0) ? 5'd1 : wdata_q[4:0];
        2'd2: upper_q <= wdata_q[1:0];
        2'd3: mode_q <= wdata_q[0];
        default: ;
      endcase
    end
  end

  assign rom_we = cmd_i.mem_go && (op_q == mbcbm_pkg::OP_LOAD_ROM) &&
                  ({1'b0, off_q} < (OW + 1)'(ROM_BYTES));
  assign rom_re = cmd_i.mem_go && is_read && rom_rgn;
  assign ram_we = cmd_i.mem_go &&
                  (((op_q == mbcbm_pkg::OP_LOAD_RAM) &&
                    ({1'b0, off_q} < (OW + 1)'(RAM_BYTES))) ||
                   (is_write && ram_rgn && ram_live));
  assign ram_re = cmd_i.mem_go && is_read && ram_rgn && ram_live;

  assign rom_lin  = {rem_q, addr_q[13:0]};
  assign ram_lin  = {rem_q, addr_q[12:0]};
  assign rom_addr = (op_q == mbcbm_pkg::OP_LOAD_ROM) ? off_q[ROM_AW-1:0]
                                                     : rom_lin[ROM_AW-1:0];
  assign ram_addr = (op_q == mbcbm_pkg::OP_LOAD_RAM) ? off_q[RAM_AW-1:0]
                                                     : ram_lin[RAM_AW-1:0];

  mbcbm_ram #(
    .WIDTH (8),
    .DEPTH (ROM_BYTES)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (rom_we),
    .re_i    (rom_re),
    .addr_i  (rom_addr),
    .wdata_i (wdata_q),
    .rdata_o (rom_rdata)
  );

  mbcbm_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_xram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (wdata_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (!is_read) begin
      result = 8'd0;
    end else if (rom_rgn) begin
      result = rom_rdata;
    end else if (ram_rgn && ram_live) begin
      result = ram_rdata;
    end else begin
      result = mbcbm_pkg::READ_OPEN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      read_data_o <= result;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mbc1_bank_mapper.sv =====
// MBC1 cartridge bank mapper: one bus access or store load per item, one
// result item per input item. Depends on mbcbm_pkg, mbcbm_ctrl and mbcbm_dp.
//
// Items that read ROM (0x0000-0x7FFF) or reach enabled external RAM
// (0xA000-0xBFFF) pass through the bank-number reduction, a restoring
// remainder unit that retires one of the 7 bank bits per cycle; other items
// skip it. Every item then passes the single-port store access state and a
// state that registers the result once the output register is free. The
// next item is taken while a finished result still waits in the output
// register. ROM and RAM contents are undefined until loaded; configuration
// may only be written while the block is idle.
`default_nettype none

module mbc1_bank_mapper #(
  parameter int unsigned ROM_BANKS_MAX = 128,
  parameter int unsigned RAM_BANKS_MAX = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] bus_address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [20:0] load_offset_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o
);

  mbcbm_pkg::ctl_cmd_t cmd;
  mbcbm_pkg::dp_stat_t stat;

  mbcbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mbcbm_dp #(
    .ROM_BANKS_MAX (ROM_BANKS_MAX),
    .RAM_BANKS_MAX (RAM_BANKS_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (op_i),
    .bus_address_i (bus_address_i),
    .write_data_i  (write_data_i),
    .load_offset_i (load_offset_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .read_data_o   (read_data_o)
  );

endmodule

`default_nettype wire
